// File: src/stcm_pkg.sv
package stcm_pkg;

    // Map and sprite geometry; tile sizes and column count are powers of two
    localparam int TILE_W    = 8;
    localparam int TILE_H    = 8;
    localparam int SPRITE_W  = 16;
    localparam int SPRITE_H  = 16;
    localparam int MAP_COLS  = 64;
    localparam int MAP_ROWS  = 64;
    localparam int TILE_W_LG = $clog2(TILE_W);
    localparam int TILE_H_LG = $clog2(TILE_H);
    localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    // Field widths
    localparam int POS_IN_W  = 11;
    localparam int POS_W     = 12;
    localparam int WIDE_W    = 13;
    localparam int VEL_W     = 8;
    localparam int CODE_W    = 8;
    localparam int CELL_W    = 6;
    localparam int TIDX_W    = 9;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 32;

    typedef logic signed [POS_IN_W-1:0] t_pos_in;
    typedef logic signed [POS_W-1:0]    t_pos;
    typedef logic signed [WIDE_W-1:0]   t_wide;
    typedef logic signed [VEL_W-1:0]    t_vel;
    typedef logic signed [TIDX_W-1:0]   t_tidx;
    typedef logic [CODE_W-1:0]          t_code;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [3:0]                 t_pc;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_ADD,
        OP_TILES,
        OP_RES_Y,
        OP_RES_X,
        OP_OVL_INIT,
        OP_OVL_STEP,
        OP_OUT
    } t_op;

    // Map read address sources
    typedef enum logic [2:0] {
        RS_NONE,
        RS_LX_PY,
        RS_RX_PY,
        RS_PX_TY,
        RS_PX_BY,
        RS_CX_CY
    } t_rsel;

    // Jump conditions
    typedef enum logic [3:0] {
        J_NEVER,
        J_ALWAYS,
        J_MOVE,
        J_MASK0,
        J_NO_OBST,
        J_VY0,
        J_VX0,
        J_NO_OTHER,
        J_OVL_LAST,
        J_OUT_FREE
    } t_jc;

    typedef struct packed {
        t_op   op;
        t_rsel rsel;
        logic  hit_clr;
        logic  probe;
        logic  acc;
        t_jc   jc;
        logic  stay;
        t_pc   tgt;
    } t_ctrl;

    // Program steps
    localparam t_pc PC_WAIT     = 4'd0;
    localparam t_pc PC_ADD      = 4'd1;
    localparam t_pc PC_TILES    = 4'd2;
    localparam t_pc PC_CHK_VY   = 4'd3;
    localparam t_pc PC_YP1      = 4'd4;
    localparam t_pc PC_YP2      = 4'd5;
    localparam t_pc PC_YRES     = 4'd6;
    localparam t_pc PC_XP1      = 4'd7;
    localparam t_pc PC_XP2      = 4'd8;
    localparam t_pc PC_XRES     = 4'd9;
    localparam t_pc PC_OVL_CHK  = 4'd10;
    localparam t_pc PC_OVL      = 4'd11;
    localparam t_pc PC_OVL_LAST = 4'd12;
    localparam t_pc PC_OUT      = 4'd13;

    // Control store
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl c;
        c = '{op: OP_NOP, rsel: RS_NONE, hit_clr: 1'b0, probe: 1'b0, acc: 1'b0,
              jc: J_NEVER, stay: 1'b0, tgt: PC_WAIT};
        unique case (pc)
            PC_WAIT: begin
                c.op = OP_WAIT; c.jc = J_MOVE; c.stay = 1'b1; c.tgt = PC_ADD;
            end
            PC_ADD: begin
                c.op = OP_ADD; c.jc = J_MASK0; c.tgt = PC_OUT;
            end
            PC_TILES: begin
                c.op = OP_TILES; c.jc = J_NO_OBST; c.tgt = PC_OVL_CHK;
            end
            PC_CHK_VY: begin
                c.jc = J_VY0; c.tgt = PC_XP1;
            end
            PC_YP1: begin
                c.rsel = RS_LX_PY; c.probe = 1'b1; c.hit_clr = 1'b1;
            end
            PC_YP2: begin
                c.rsel = RS_RX_PY; c.probe = 1'b1;
            end
            PC_YRES: begin
                c.op = OP_RES_Y;
            end
            PC_XP1: begin
                c.rsel = RS_PX_TY; c.probe = 1'b1; c.hit_clr = 1'b1;
                c.jc = J_VX0; c.tgt = PC_OVL_CHK;
            end
            PC_XP2: begin
                c.rsel = RS_PX_BY; c.probe = 1'b1;
            end
            PC_XRES: begin
                c.op = OP_RES_X;
            end
            PC_OVL_CHK: begin
                c.op = OP_OVL_INIT; c.jc = J_NO_OTHER; c.tgt = PC_OUT;
            end
            PC_OVL: begin
                c.op = OP_OVL_STEP; c.rsel = RS_CX_CY; c.acc = 1'b1;
                c.jc = J_OVL_LAST; c.stay = 1'b1; c.tgt = PC_OVL_LAST;
            end
            PC_OVL_LAST: begin
                c.op = OP_NOP;
            end
            PC_OUT: begin
                c.op = OP_OUT; c.jc = J_OUT_FREE; c.stay = 1'b1; c.tgt = PC_WAIT;
            end
            default: begin
                c.jc = J_ALWAYS; c.tgt = PC_WAIT;
            end
        endcase
        return c;
    endfunction

    // Pixel to tile index, truncating toward zero
    function automatic t_tidx tdiv_x(input t_wide v);
        t_wide b;
        b = v[WIDE_W-1] ? t_wide'(v + t_wide'(TILE_W - 1)) : v;
        return t_tidx'(b >>> TILE_W_LG);
    endfunction

    function automatic t_tidx tdiv_y(input t_wide v);
        t_wide b;
        b = v[WIDE_W-1] ? t_wide'(v + t_wide'(TILE_H - 1)) : v;
        return t_tidx'(b >>> TILE_H_LG);
    endfunction

endpackage

// File: src/sprite_tile_collision_mover.sv
// Sprite mover with tile-map collision. A tile write (tuser = 1) gives no result.
// A move (tuser = 0) gives one result, and a move with a zero mask skips the map
// reads. Every corner probe and every overlap read (the sprite overlaps at most 9
// cells with the default sizes) goes through the single read port of the map memory
// one cell a cycle under a microcoded step sequencer. After reset the map is swept
// to zero, one cell a cycle, with s_axis_tready low; the obstacle register
// may be written whenever no move is in flight. A finished result waits in the
// output register while the next item is taken.
module sprite_tile_collision_mover (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [stcm_pkg::CODE_W-1:0]    i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x[10:0], pos_y[21:11], vel_x[29:22], vel_y[37:30], coll_mask[45:38],
    // cell_col[51:46], cell_row[57:52], cell_code[65:58], zero fill
    input  logic [stcm_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // new_x[11:0], new_y[23:12], collision_flags[31:24]
    output logic [stcm_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // flags_updated
    output logic [0:0]                     m_axis_tuser
);
    import stcm_pkg::*;

    // Map memory and clearing sweep
    t_code mem [MAP_DEPTH];
    logic  r_clr_busy;
    t_addr r_clr_addr;
    t_code r_rd_data;
    logic  r_rd_oob;

    // Sequencer and datapath registers
    t_pc     r_pc;
    t_pc     n_pc;
    t_ctrl   ctrl;
    t_code   r_obst;
    t_pos_in r_ox, r_oy;
    t_vel    r_vx, r_vy;
    t_code   r_mask;
    t_pos    r_nx, r_ny;
    t_tidx   r_lx, r_rx, r_ty, r_by;
    t_tidx   r_cx, r_cy;
    t_code   r_flags;
    logic    r_hit, r_probe_pend, r_acc_pend;
    logic    r_out_valid;
    t_pos    r_o_nx, r_o_ny;
    t_code   r_o_flags;
    logic    r_o_upd;

    logic    s_xfer, move_acc, out_free, cond;
    logic    blk_now, hit_now;
    t_code   rd_code;
    t_tidx   rd_col, rd_row, py, px;
    logic    rd_oob;
    t_addr   rd_addr, wr_addr;
    logic    wr_en;

    assign ctrl          = ucode(r_pc);
    assign s_axis_tready = (r_pc == PC_WAIT) && !r_clr_busy;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign move_acc      = s_xfer && !s_axis_tuser[0];
    assign out_free      = !r_out_valid || m_axis_tready;

    // Read data of the previous cycle's probe
    assign rd_code = r_rd_oob ? '0 : r_rd_data;
    assign blk_now = (rd_code & r_obst) != '0;
    assign hit_now = r_hit || (r_probe_pend && blk_now);

    // Leading edges
    assign py = r_vy[VEL_W-1] ? r_ty : r_by;
    assign px = r_vx[VEL_W-1] ? r_lx : r_rx;

    // Read address selection
    always_comb begin
        unique case (ctrl.rsel)
            RS_LX_PY: begin rd_col = r_lx; rd_row = py;   end
            RS_RX_PY: begin rd_col = r_rx; rd_row = py;   end
            RS_PX_TY: begin rd_col = px;   rd_row = r_ty; end
            RS_PX_BY: begin rd_col = px;   rd_row = r_by; end
            RS_CX_CY: begin rd_col = r_cx; rd_row = r_cy; end
            default:  begin rd_col = r_cx; rd_row = r_cy; end
        endcase
    end

    assign rd_oob  = (rd_col < 0) || (rd_row < 0) ||
                     (int'(rd_col) >= MAP_COLS) || (int'(rd_row) >= MAP_ROWS);
    assign rd_addr = ADDR_W'(int'(rd_row) * MAP_COLS + int'(rd_col));

    // Tile write from a write transfer
    assign wr_addr = ADDR_W'(int'(s_axis_tdata[57:52]) * MAP_COLS + int'(s_axis_tdata[51:46]));
    assign wr_en   = s_xfer && s_axis_tuser[0] &&
                     (int'(s_axis_tdata[51:46]) < MAP_COLS) &&
                     (int'(s_axis_tdata[57:52]) < MAP_ROWS);

    // Map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= s_axis_tdata[65:58];
        end
        r_rd_data <= mem[rd_addr];
        r_rd_oob  <= rd_oob;
    end

    // Jump condition
    always_comb begin
        unique case (ctrl.jc)
            J_NEVER:    cond = 1'b0;
            J_ALWAYS:   cond = 1'b1;
            J_MOVE:     cond = move_acc;
            J_MASK0:    cond = (r_mask == '0);
            J_NO_OBST:  cond = ((r_mask & r_obst) == '0);
            J_VY0:      cond = (r_vy == '0);
            J_VX0:      cond = (r_vx == '0);
            J_NO_OTHER: cond = ((r_mask & ~r_obst) == '0);
            J_OVL_LAST: cond = (r_cx == r_rx) && (r_cy == r_by);
            J_OUT_FREE: cond = out_free;
            default:    cond = 1'b0;
        endcase
        if (cond) begin
            n_pc = ctrl.tgt;
        end else if (ctrl.stay) begin
            n_pc = r_pc;
        end else begin
            n_pc = t_pc'(r_pc + 4'd1);
        end
    end

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_WAIT;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_obst       <= CODE_W'(1);
            r_probe_pend <= 1'b0;
            r_acc_pend   <= 1'b0;
            r_hit        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc         <= n_pc;
            r_probe_pend <= ctrl.probe;
            r_acc_pend   <= ctrl.acc;

            // clearing sweep
            if (r_clr_busy) begin
                r_clr_addr <= t_addr'(r_clr_addr + 1'b1);
                if (int'(r_clr_addr) == MAP_DEPTH - 1) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (i_cfg_we) begin
                r_obst <= i_cfg_wdata;
            end

            // probe hit collection
            if (ctrl.hit_clr) begin
                r_hit <= 1'b0;
            end else begin
                r_hit <= hit_now;
            end

            // overlap OR of the previous read
            if (r_acc_pend) begin
                r_flags <= r_flags | rd_code;
            end

            // output drained; a reload in the same cycle is handled by OP_OUT
            if (r_out_valid && m_axis_tready && (ctrl.op != OP_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (ctrl.op)
                OP_WAIT: begin
                    if (move_acc) begin
                        r_ox   <= s_axis_tdata[10:0];
                        r_oy   <= s_axis_tdata[21:11];
                        r_vx   <= s_axis_tdata[29:22];
                        r_vy   <= s_axis_tdata[37:30];
                        r_mask <= s_axis_tdata[45:38];
                    end
                end
                OP_ADD: begin
                    r_nx    <= t_pos'(r_ox) + t_pos'(r_vx);
                    r_ny    <= t_pos'(r_oy) + t_pos'(r_vy);
                    r_flags <= '0;
                end
                OP_TILES: begin
                    r_lx <= tdiv_x(t_wide'(r_nx));
                    r_rx <= tdiv_x(t_wide'(r_nx) + t_wide'(SPRITE_W - 1));
                    r_ty <= tdiv_y(t_wide'(r_ny));
                    r_by <= tdiv_y(t_wide'(r_ny) + t_wide'(SPRITE_H - 1));
                end
                OP_RES_Y: begin
                    if (hit_now) begin
                        r_ny    <= t_pos'(r_oy);
                        r_ty    <= tdiv_y(t_wide'(r_oy));
                        r_by    <= tdiv_y(t_wide'(r_oy) + t_wide'(SPRITE_H - 1));
                        r_flags <= r_obst;
                    end
                end
                OP_RES_X: begin
                    if (hit_now) begin
                        r_nx    <= t_pos'(r_ox);
                        r_lx    <= tdiv_x(t_wide'(r_ox));
                        r_rx    <= tdiv_x(t_wide'(r_ox) + t_wide'(SPRITE_W - 1));
                        r_flags <= r_obst;
                    end
                end
                OP_OVL_INIT: begin
                    r_cx <= r_lx;
                    r_cy <= r_ty;
                end
                OP_OVL_STEP: begin
                    // raster walk over the overlapped cells
                    if (r_cx == r_rx) begin
                        r_cx <= r_lx;
                        r_cy <= t_tidx'(r_cy + t_tidx'(1));
                    end else begin
                        r_cx <= t_tidx'(r_cx + t_tidx'(1));
                    end
                end
                OP_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_nx      <= r_nx;
                        r_o_ny      <= r_ny;
                        r_o_flags   <= (r_mask != '0) ? r_flags : '0;
                        r_o_upd     <= (r_mask != '0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_o_flags, r_o_ny, r_o_nx};
    assign m_axis_tuser  = r_o_upd;

endmodule

// File: test/stcm_tb_pkg.sv
`timescale 1ns / 1ps
package stcm_tb_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [0:0] {
        REQ_MOVE  = 1'b0,
        REQ_WRITE = 1'b1
    } t_req;

    // Obstacle register value after reset
    localparam logic [7:0] OBSTACLE_RESET = 8'h01;

endpackage

// File: test/sprite_tile_collision_mover_checker.sv
`timescale 1ns / 1ps
module sprite_tile_collision_mover_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [stcm_pkg::CODE_W-1:0]    i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // pos_x, pos_y, vel_x, vel_y, coll_mask, cell_col, cell_row, cell_code, zero fill
    input  logic [stcm_pkg::S_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // new_x, new_y, collision_flags
    input  logic [stcm_pkg::M_DATA_W-1:0]  i_m_tdata,
    // flags_updated
    input  logic [0:0]                     i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);
    import stcm_pkg::*;
    import stcm_tb_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_pos  x;
        t_pos  y;
        t_code flags;
        logic  updated;
    } t_move_result;

    t_code        tile_map [MAP_DEPTH];
    t_code        obstacle_bits = OBSTACLE_RESET;
    t_move_result expected_moves [$];
    int           fail_count = 0;

    // Map read; anything off the map reads as an empty tile
    function automatic t_code code_at(input int cx, input int cy);
        if (cx < 0 || cy < 0 || cx >= MAP_COLS || cy >= MAP_ROWS)
            return '0;
        return tile_map[cy * MAP_COLS + cx];
    endfunction

    function automatic logic is_blocking(input int cx, input int cy);
        return (code_at(cx, cy) & obstacle_bits) != '0;
    endfunction

    // Expected outcome of one move request against the current map
    function automatic t_move_result resolve_move(input logic [S_DATA_W-1:0] d);
        t_pos_in      px, py;
        t_vel         vx, vy;
        t_code        mask;
        int           ox, oy, nx, ny, lx, rx, ty, by, lead;
        t_move_result r;
        px   = d[10:0];
        py   = d[21:11];
        vx   = d[29:22];
        vy   = d[37:30];
        mask = d[45:38];
        ox   = px;
        oy   = py;
        nx   = ox + int'(vx);
        ny   = oy + int'(vy);
        r.flags   = '0;
        r.updated = (mask != '0);
        if (r.updated) begin
            // tile indices truncate toward zero, as int division does
            lx = nx / TILE_W;
            rx = (nx + SPRITE_W - 1) / TILE_W;
            ty = ny / TILE_H;
            by = (ny + SPRITE_H - 1) / TILE_H;
            if ((mask & obstacle_bits) != '0) begin
                // leading edge in Y first, then X against the settled Y
                if (vy != 0) begin
                    lead = (vy < 0) ? ty : by;
                    if (is_blocking(lx, lead) || is_blocking(rx, lead)) begin
                        ny = oy;
                        ty = ny / TILE_H;
                        by = (ny + SPRITE_H - 1) / TILE_H;
                        r.flags = obstacle_bits;
                    end
                end
                if (vx != 0) begin
                    lead = (vx < 0) ? lx : rx;
                    if (is_blocking(lead, ty) || is_blocking(lead, by)) begin
                        nx = ox;
                        lx = nx / TILE_W;
                        rx = (nx + SPRITE_W - 1) / TILE_W;
                        r.flags = obstacle_bits;
                    end
                end
            end
            // other kinds: OR of every overlapped cell at the final position
            if ((mask & ~obstacle_bits) != '0) begin
                for (int cy = ty; cy <= by; cy++)
                    for (int cx = lx; cx <= rx; cx++)
                        r.flags |= code_at(cx, cy);
            end
        end
        r.x = t_pos'(nx);
        r.y = t_pos'(ny);
        return r;
    endfunction

    task automatic log_fault(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Channel monitor: outputs are checked before the same edge's input is modelled
    always @(posedge i_clk) begin : watch
        t_move_result want;
        t_pos         got_x;
        t_pos         got_y;
        t_code        got_flags;
        int           col;
        int           row;
        if (!i_rst_n) begin
            foreach (tile_map[i])
                tile_map[i] = '0;
            obstacle_bits = OBSTACLE_RESET;
            expected_moves.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_x     = i_m_tdata[11:0];
                got_y     = i_m_tdata[23:12];
                got_flags = i_m_tdata[31:24];
                if (expected_moves.size() == 0) begin
                    log_fault($sformatf("unexpected result: x %0d y %0d flags %02h upd %0b",
                                        got_x, got_y, got_flags, i_m_tuser[0]));
                end else begin
                    want = expected_moves.pop_front();
                    if (got_x != want.x || got_y != want.y || got_flags != want.flags
                            || i_m_tuser[0] !== want.updated)
                        log_fault($sformatf({"result mismatch: exp x %0d y %0d flags %02h ",
                                             "upd %0b, got x %0d y %0d flags %02h upd %0b"},
                                            want.x, want.y, want.flags, want.updated,
                                            got_x, got_y, got_flags, i_m_tuser[0]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_req'(i_s_tuser) == REQ_WRITE) begin
                    col = i_s_tdata[51:46];
                    row = i_s_tdata[57:52];
                    if (col < MAP_COLS && row < MAP_ROWS)
                        tile_map[row * MAP_COLS + col] = i_s_tdata[65:58];
                end else begin
                    expected_moves.push_back(resolve_move(i_s_tdata));
                end
            end
            if (i_cfg_we)
                obstacle_bits = i_cfg_wdata;
        end
        o_pending    = expected_moves.size();
        o_fail_count = fail_count;
    end

endmodule

// File: test/sprite_tile_collision_mover_tb.sv
`timescale 1ns / 1ps
module sprite_tile_collision_mover_tb;
    import stcm_pkg::*;
    import stcm_tb_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 12000;   // covers the map sweep after reset
    localparam int SETTLE_CYCLES  = 24;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 95;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CODE_W-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int    fail_count;
    int    pending;
    int    quiet_cycles = 0;
    logic  gaps_on      = 1'b1;
    logic  hold_req     = 1'b0;
    logic  hold_done    = 1'b0;
    t_code obstacle_now = OBSTACLE_RESET;

    sprite_tile_collision_mover dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sprite_tile_collision_mover_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Result side: random back-pressure bursts, plus one long hold on request
    initial begin : sink
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stall watchdog: cycles without a transfer on either channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sprite_tile_collision_mover verification failed");
                $finish;
            end
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(
        input int px, input int py, input int vx, input int vy, input t_code mask,
        input int col, input int row, input t_code code);
        return S_DATA_W'({code, CELL_W'(row), CELL_W'(col), mask, t_vel'(vy), t_vel'(vx),
                          t_pos_in'(py), t_pos_in'(px)});
    endfunction

    // One input transfer, optionally followed by an idle burst
    task automatic offer(input t_req kind, input logic [S_DATA_W-1:0] payload);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_move(input int px, input int py, input int vx, input int vy,
                             input t_code mask);
        offer(REQ_MOVE, pack_item(px, py, vx, vy, mask, $urandom_range(0, 63),
                                  $urandom_range(0, 63), t_code'($urandom)));
    endtask

    task automatic send_write(input int col, input int row, input t_code code);
        offer(REQ_WRITE, pack_item($urandom, $urandom, $urandom, $urandom, t_code'($urandom),
                                   col, row, code));
    endtask

    // Sender pause until every result is back, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_obstacle(input t_code v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        obstacle_now = v;
    endtask

    task automatic random_item();
        int    pick;
        int    c;
        int    r;
        int    px;
        int    py;
        int    vx;
        int    vy;
        t_code code;
        t_code mask;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            // tile write, then a sprite heading straight at that tile
            c    = $urandom_range(1, 14);
            r    = $urandom_range(1, 14);
            code = t_code'($urandom);
            if ($urandom_range(0, 2) != 0)
                code |= obstacle_now;
            send_write(c, r, code);
            case ($urandom_range(0, 3))
                0: begin
                    px = c * TILE_W - int'($urandom_range(0, SPRITE_W + 2));
                    py = r * TILE_H - SPRITE_H - int'($urandom_range(0, 6));
                    vx = int'($urandom_range(0, 6)) - 3;
                    vy = int'($urandom_range(1, 14));
                end
                1: begin
                    px = c * TILE_W - int'($urandom_range(0, SPRITE_W + 2));
                    py = (r + 1) * TILE_H + int'($urandom_range(0, 6));
                    vx = int'($urandom_range(0, 6)) - 3;
                    vy = -int'($urandom_range(1, 14));
                end
                2: begin
                    px = c * TILE_W - SPRITE_W - int'($urandom_range(0, 6));
                    py = r * TILE_H - int'($urandom_range(0, SPRITE_H + 2));
                    vx = int'($urandom_range(1, 14));
                    vy = int'($urandom_range(0, 6)) - 3;
                end
                default: begin
                    px = (c + 1) * TILE_W + int'($urandom_range(0, 6));
                    py = r * TILE_H - int'($urandom_range(0, SPRITE_H + 2));
                    vx = -int'($urandom_range(1, 14));
                    vy = int'($urandom_range(0, 6)) - 3;
                end
            endcase
            mask = ($urandom_range(0, 3) == 0) ? t_code'($urandom)
                                               : (obstacle_now | t_code'($urandom_range(0, 3)));
            send_move(px, py, vx, vy, mask);
        end else if (pick < 55) begin
            // loose writes, mostly around the busy corner of the map
            if ($urandom_range(0, 3) == 0)
                send_write($urandom_range(0, 63), $urandom_range(0, 63), t_code'($urandom));
            else
                send_write($urandom_range(0, 15), $urandom_range(0, 15), t_code'($urandom));
        end else if (pick < 85) begin
            mask = ($urandom_range(0, 9) == 0) ? 8'h00 : t_code'($urandom);
            send_move(int'($urandom_range(0, 170)) - 30, int'($urandom_range(0, 170)) - 30,
                      int'($urandom_range(0, 24)) - 12, int'($urandom_range(0, 24)) - 12, mask);
        end else begin
            send_move($urandom, $urandom, $urandom, $urandom, t_code'($urandom));
        end
    endtask

    initial begin : stimulus
        t_code setting;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: map seeding, field extremes, hits on each edge, off-map reads
        send_write(5, 5, 8'h01);
        send_write(63, 63, 8'hFF);
        send_write(0, 0, 8'h7E);
        send_write(2, 5, 8'h80);
        send_move(1023, 1023, 127, 127, 8'h00);
        send_move(-1024, -1024, -128, -128, 8'h00);
        send_move(-1024, 1023, 127, -128, 8'hFF);
        send_move(32, 20, 0, 8, 8'h01);
        send_move(20, 40, 8, 0, 8'h01);
        send_move(40, 54, 0, -8, 8'hFF);
        send_move(55, 40, -10, 0, 8'h03);
        send_move(-20, -20, -5, -5, 8'hFF);
        send_move(500, 500, 3, 3, 8'h02);
        send_move(0, 0, 0, 0, 8'hFF);
        send_move(-9, -9, 2, 2, 8'hFE);
        send_move(28, 28, 6, 6, 8'h01);
        send_move(1023, -1024, -1, 1, 8'hFF);
        send_move(10, 30, 0, 0, 8'h80);

        // Random phases, one obstacle setting each; the last runs without idling
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       setting = 8'h00;
                1:       setting = 8'hFF;
                2:       setting = 8'h80;
                3:       setting = t_code'($urandom);
                4:       setting = 8'h06;
                default: setting = OBSTACLE_RESET;
            endcase
            write_obstacle(setting);
            gaps_on = (ph < PHASES - 1);
            if (ph == 2)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) random_item();
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("sprite_tile_collision_mover verification clean");
        else
            $display("sprite_tile_collision_mover verification failed");
        $finish;
    end

endmodule
